[rtl/core/spq3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq3_pkg
// Shared constants, status codes and control bundles for the three-level
// strict-priority queue.
// ----------------------------------------------------------------------------
package spq3_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_CLASSES = 3;

    localparam int ID_W     = 16;
    localparam int AGE_W    = 8;
    localparam int CODE_W   = 3;
    localparam int STATUS_W = 3;
    localparam int CLS_W    = 2;
    localparam int MAP_W    = 10;
    localparam int REC_W    = ID_W + AGE_W;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(MEM_DEPTH);

    localparam logic [MAP_W-1:0] CLASS_MAP_RESET = MAP_W'(580);

    localparam logic [CODE_W-1:0] CODE_MIN = CODE_W'(1);
    localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(5);

    localparam logic FUNC_ENQUEUE = 1'b0;
    localparam logic FUNC_SERVE   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_SERVED   = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] STATUS_FULL     = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] STATUS_BAD_CAT  = STATUS_W'(4);

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the accepted input transaction
        logic exec;      // decide, update queue state, launch store access
        logic load;      // move the result into the output register
    } spq3_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } spq3_sts_t;

endpackage

[rtl/core/strict_priority_three_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_three_queue
// Three FIFO record queues served in strict class priority.
//
// Input channel (in_valid/in_ready): func selects enqueue or serve. An
// enqueue maps category_code through the class_map register to a class and
// appends {record_id, record_age} to that class's queue. A serve pops the
// head of the lowest-numbered non-empty class.
// Output channel (out_valid/out_ready): one result transaction per input
// transaction, in order, with status and the served record.
// Config: cfg_we writes cfg_wdata into class_map; write only while idle.
// The result is registered through the capture, execute-stage and output
// registers. A new transaction is accepted only after the previous one has
// passed accept / execute / load around the single-port record store.
// A result waiting in the output register does not block the next accept.
// Reset: all queues empty, class_map back to its default; no clear pass.
// Receiver stall: the result holds; the sequencer waits in its load step.
// ----------------------------------------------------------------------------
module strict_priority_three_queue
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [spq3_pkg::MAP_W-1:0]    cfg_wdata,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [spq3_pkg::ID_W-1:0]     record_id,
    input  logic [spq3_pkg::AGE_W-1:0]    record_age,
    input  logic [spq3_pkg::CODE_W-1:0]   category_code,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [spq3_pkg::STATUS_W-1:0] status,
    output logic [spq3_pkg::ID_W-1:0]     served_id,
    output logic [spq3_pkg::AGE_W-1:0]    served_age,
    output logic [spq3_pkg::CLS_W-1:0]    served_class
);

    spq3_pkg::spq3_cmd_t cmd;
    spq3_pkg::spq3_sts_t sts;

    // sequencer: advance one transaction through accept, execute, load
    spq3_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // queue state, record store and output register
    spq3_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .func          (func),
        .record_id     (record_id),
        .record_age    (record_age),
        .category_code (category_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .served_id     (served_id),
        .served_age    (served_age),
        .served_class  (served_class)
    );

endmodule

[rtl/core/spq3_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq3_ctrl
// Sequencer: accept one transaction, execute it, then load its result.
// ----------------------------------------------------------------------------
module spq3_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  spq3_pkg::spq3_sts_t sts,
    output spq3_pkg::spq3_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // hold until the output register frees up
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/spq3_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq3_dpath
// Class map, per-class head/tail/fill state, record store and result register.
// ----------------------------------------------------------------------------
module spq3_dpath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  spq3_pkg::spq3_cmd_t               cmd,
    output spq3_pkg::spq3_sts_t               sts,

    input  logic                              cfg_we,
    input  logic [spq3_pkg::MAP_W-1:0]        cfg_wdata,

    input  logic                              func,
    input  logic [spq3_pkg::ID_W-1:0]         record_id,
    input  logic [spq3_pkg::AGE_W-1:0]        record_age,
    input  logic [spq3_pkg::CODE_W-1:0]       category_code,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [spq3_pkg::STATUS_W-1:0]     status,
    output logic [spq3_pkg::ID_W-1:0]         served_id,
    output logic [spq3_pkg::AGE_W-1:0]        served_age,
    output logic [spq3_pkg::CLS_W-1:0]        served_class
);

    localparam int NC = spq3_pkg::NUM_CLASSES;

    logic [spq3_pkg::MAP_W-1:0]    class_map_reg;

    // captured transaction
    logic                          func_reg;
    logic [spq3_pkg::REC_W-1:0]    rec_reg;
    logic [spq3_pkg::CODE_W-1:0]   code_reg;

    // queue bookkeeping
    logic [spq3_pkg::PTR_W-1:0]    head_reg [NC];
    logic [spq3_pkg::PTR_W-1:0]    tail_reg [NC];
    logic [spq3_pkg::CNT_W-1:0]    fill_reg [NC];

    logic [spq3_pkg::REC_W-1:0]    record_store_reg [spq3_pkg::MEM_DEPTH];
    logic [spq3_pkg::REC_W-1:0]    rd_data_reg;

    // execute-stage result
    logic [spq3_pkg::STATUS_W-1:0] res_status_reg;
    logic [spq3_pkg::CLS_W-1:0]    res_cls_reg;

    // output register
    logic                          out_valid_reg;
    logic [spq3_pkg::STATUS_W-1:0] out_status_reg;
    logic [spq3_pkg::ID_W-1:0]     out_id_reg;
    logic [spq3_pkg::AGE_W-1:0]    out_age_reg;
    logic [spq3_pkg::CLS_W-1:0]    out_cls_reg;

    // decode
    logic [spq3_pkg::CODE_W-1:0]   code_m1;
    logic [spq3_pkg::CLS_W-1:0]    map_cls;
    logic                          bad_cat;
    logic [spq3_pkg::CIDX_W-1:0]   enq_idx;
    logic                          enq_full;
    logic                          srv_found;
    logic [spq3_pkg::CIDX_W-1:0]   srv_idx;
    logic [spq3_pkg::STATUS_W-1:0] exec_status;
    logic                          do_enq;
    logic                          do_srv;
    logic [spq3_pkg::ADDR_W-1:0]   wr_addr;
    logic [spq3_pkg::ADDR_W-1:0]   rd_addr;

    always_comb
    begin
        code_m1 = code_reg - spq3_pkg::CODE_MIN;
        map_cls = spq3_pkg::CLS_W'(class_map_reg >> {code_m1, 1'b0});
        bad_cat = (code_reg < spq3_pkg::CODE_MIN) || (code_reg > spq3_pkg::CODE_MAX)
                  || ({1'b0, map_cls} >= 3'(NC));
        enq_idx  = spq3_pkg::CIDX_W'(map_cls);
        enq_full = bad_cat ? 1'b0
                 : (fill_reg[enq_idx] == spq3_pkg::CNT_W'(spq3_pkg::QUEUE_DEPTH));

        // lowest-numbered non-empty class wins
        srv_found = 1'b0;
        srv_idx   = '0;
        for (int c = NC - 1; c >= 0; c--)
        begin
            if (fill_reg[c] != '0)
            begin
                srv_found = 1'b1;
                srv_idx   = spq3_pkg::CIDX_W'(c);
            end
        end

        do_enq = 1'b0;
        do_srv = 1'b0;
        if (func_reg == spq3_pkg::FUNC_ENQUEUE)
        begin
            priority if (bad_cat)
            begin
                exec_status = spq3_pkg::STATUS_BAD_CAT;
            end
            else if (enq_full)
            begin
                exec_status = spq3_pkg::STATUS_FULL;
            end
            else
            begin
                exec_status = spq3_pkg::STATUS_ENQUEUED;
                do_enq      = cmd.exec;
            end
        end
        else
        begin
            if (srv_found)
            begin
                exec_status = spq3_pkg::STATUS_SERVED;
                do_srv      = cmd.exec;
            end
            else
            begin
                exec_status = spq3_pkg::STATUS_EMPTY;
            end
        end

        wr_addr = spq3_pkg::ADDR_W'(spq3_pkg::ADDR_W'(enq_idx)
                  * spq3_pkg::ADDR_W'(spq3_pkg::QUEUE_DEPTH)
                  + spq3_pkg::ADDR_W'(tail_reg[enq_idx]));
        rd_addr = spq3_pkg::ADDR_W'(spq3_pkg::ADDR_W'(srv_idx)
                  * spq3_pkg::ADDR_W'(spq3_pkg::QUEUE_DEPTH)
                  + spq3_pkg::ADDR_W'(head_reg[srv_idx]));
    end

    function automatic logic [spq3_pkg::PTR_W-1:0] next_slot(
        input logic [spq3_pkg::PTR_W-1:0] p
    );
        return (p == spq3_pkg::PTR_W'(spq3_pkg::QUEUE_DEPTH - 1)) ? '0
               : spq3_pkg::PTR_W'(p + 1'b1);
    endfunction

    // configuration and bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_map_reg <= spq3_pkg::CLASS_MAP_RESET;
            for (int c = 0; c < NC; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                class_map_reg <= cfg_wdata;
            end
            if (do_enq)
            begin
                tail_reg[enq_idx] <= next_slot(tail_reg[enq_idx]);
                fill_reg[enq_idx] <= fill_reg[enq_idx] + 1'b1;
            end
            if (do_srv)
            begin
                head_reg[srv_idx] <= next_slot(head_reg[srv_idx]);
                fill_reg[srv_idx] <= fill_reg[srv_idx] - 1'b1;
            end
        end
    end

    // record store: one write or one read per transaction
    always_ff @(posedge clk)
    begin
        if (do_enq)
        begin
            record_store_reg[wr_addr] <= rec_reg;
        end
        if (do_srv)
        begin
            rd_data_reg <= record_store_reg[rd_addr];
        end
    end

    // payload capture, execute-stage result and output register, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            rec_reg  <= {record_id, record_age};
            code_reg <= category_code;
        end
        if (cmd.exec)
        begin
            res_status_reg <= exec_status;
            res_cls_reg    <= spq3_pkg::CLS_W'(srv_idx);
        end
        if (cmd.load)
        begin
            out_status_reg <= res_status_reg;
            if (res_status_reg == spq3_pkg::STATUS_SERVED)
            begin
                out_id_reg  <= rd_data_reg[spq3_pkg::REC_W-1:spq3_pkg::AGE_W];
                out_age_reg <= rd_data_reg[spq3_pkg::AGE_W-1:0];
                out_cls_reg <= res_cls_reg;
            end
            else
            begin
                out_id_reg  <= '0;
                out_age_reg <= '0;
                out_cls_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign served_id    = out_id_reg;
    assign served_age   = out_age_reg;
    assign served_class = out_cls_reg;

endmodule
